FILE: design/dpo_pkg.sv
// shared types, constants and calendar tables for the date period overlap block
package dpo_pkg;

   localparam int DayW    = 5;
   localparam int MonW    = 4;
   localparam int YearW   = 14;
   localparam int CountW  = 22;
   localparam int NumW    = 23;   // linear day number width
   localparam int ShiftYW = 15;   // year plus one 400-year cycle
   localparam int QuotW   = 8;    // year / 100
   localparam int ProdW   = 28;
   localparam int KW      = 13;

   localparam logic [KW-1:0] RecipHundred = 13'd5243;   // 2^19 / 100, rounded up
   localparam int            RecipShift   = 19;
   localparam logic [KW-1:0] Hundred      = 13'd100;
   localparam logic [KW-1:0] DaysPerYear  = 13'd365;
   localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

   localparam logic [MonW-1:0] MonJan = 4'd1;
   localparam logic [MonW-1:0] MonFeb = 4'd2;
   localparam logic [MonW-1:0] MonDec = 4'd12;

   // one step of the shared conversion unit
   typedef enum logic [2:0] {
      OP_YDIV  = 3'd0,   // year / 100
      OP_YREM  = 3'd1,   // leap test from year / 100
      OP_YYDIV = 3'd2,   // shifted year / 100
      OP_YYMUL = 3'd3,   // shifted year * 365
      OP_SUM   = 3'd4    // final day number and date check
   } op_type;

   typedef struct packed {
      logic   en;
      op_type op;
   } dpo_ctl_type;

   typedef struct packed {
      logic [NumW-1:0] num;
      logic            ok;
   } dpo_res_type;

   function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m);
      logic [DayW-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // days before a month in a year that starts in march
   function automatic logic [8:0] month_off(input logic [MonW-1:0] mp);
      logic [8:0] off;
      case (mp)
         4'd0:    off = 9'd0;
         4'd1:    off = 9'd31;
         4'd2:    off = 9'd61;
         4'd3:    off = 9'd92;
         4'd4:    off = 9'd122;
         4'd5:    off = 9'd153;
         4'd6:    off = 9'd184;
         4'd7:    off = 9'd214;
         4'd8:    off = 9'd245;
         4'd9:    off = 9'd275;
         4'd10:   off = 9'd306;
         4'd11:   off = 9'd337;
         4'd12:   off = 9'd367;
         default: off = 9'd0;
      endcase
      return off;
   endfunction

endpackage

FILE: design/dpo_date_unit.sv
// shared date unit: one constant multiplier stepped to check a date and form its day number
module dpo_date_unit (
   input  logic                       clock,
   input  dpo_pkg::dpo_ctl_type       ctl,
   input  logic [dpo_pkg::DayW-1:0]   day,
   input  logic [dpo_pkg::MonW-1:0]   month,
   input  logic [dpo_pkg::YearW-1:0]  year,
   output dpo_pkg::dpo_res_type       res
);
   import dpo_pkg::*;

   logic [QuotW-1:0]   qy_ff, qy_in;
   logic               leap_ff, leap_in;
   logic [QuotW-1:0]   q100_ff, q100_in;
   logic [NumW-1:0]    base_ff, base_in;

   logic [ShiftYW-1:0] yy;
   logic [MonW-1:0]    mp;
   logic [ShiftYW-1:0] mul_a;
   logic [KW-1:0]      mul_b;
   logic [ProdW-1:0]   prod;
   logic [DayW-1:0]    len;
   logic               mon_ok;

   // march-based year, shifted by 400 years to stay positive
   always_comb begin
      if (month <= MonFeb) begin
         yy = ShiftYW'(year) + 15'd399;
         mp = month + 4'd9;
      end else begin
         yy = ShiftYW'(year) + 15'd400;
         mp = month - 4'd3;
      end
   end

   always_comb begin
      case (ctl.op)
         OP_YDIV: begin
            mul_a = ShiftYW'(year);
            mul_b = RecipHundred;
         end
         OP_YREM: begin
            mul_a = ShiftYW'(qy_ff);
            mul_b = Hundred;
         end
         OP_YYDIV: begin
            mul_a = yy;
            mul_b = RecipHundred;
         end
         OP_YYMUL: begin
            mul_a = yy;
            mul_b = DaysPerYear;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod = ProdW'(mul_a) * ProdW'(mul_b);
   end

   always_comb begin
      qy_in   = qy_ff;
      leap_in = leap_ff;
      q100_in = q100_ff;
      base_in = base_ff;
      if (ctl.en) begin
         case (ctl.op)
            OP_YDIV:  qy_in = prod[RecipShift +: QuotW];
            OP_YREM:  leap_in = (year[1:0] == 2'b00) &&
                                ((prod != ProdW'(year)) || (qy_ff[1:0] == 2'b00));
            OP_YYDIV: q100_in = prod[RecipShift +: QuotW];
            OP_YYMUL: base_in = prod[NumW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      qy_ff   <= qy_in;
      leap_ff <= leap_in;
      q100_ff <= q100_in;
      base_ff <= base_in;
   end

   always_comb begin
      len    = (month == MonFeb) ? (leap_ff ? 5'd29 : 5'd28) : month_len(month);
      mon_ok = (month >= MonJan) && (month <= MonDec);
      res.ok = mon_ok && (day != '0) && (day <= len);
      res.num = base_ff + NumW'(yy >> 2) - NumW'(q100_ff) + NumW'(q100_ff >> 2)
                + NumW'(month_off(mp)) + NumW'(day);
   end

endmodule

FILE: design/date_period_overlap_days_top.sv
// top level: item capture, step sequencer around the shared date unit, overlap count
//
//   channel   ports                            handshake
//   request   req_* (12 date fields)           taken when start && !busy
//   response  rsp_overlap_days, rsp_date_invalid  one-cycle strobe rsp_valid
//
// rsp_valid rises after the accepting edge once all four dates have gone through five
// steps each in the one shared date unit, then a compare state and a count state
// busy is high from acceptance until the cycle rsp_valid is raised, so the next
// item can be taken in the strobe cycle; no new item is taken while one is in work
// reset clears the sequencer and the strobe; no response is pending after it
// the receiver cannot stall: each result shows for exactly one cycle
module date_period_overlap_days_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [dpo_pkg::DayW-1:0]      req_first_start_day,
   input  logic [dpo_pkg::MonW-1:0]      req_first_start_month,
   input  logic [dpo_pkg::YearW-1:0]     req_first_start_year,
   input  logic [dpo_pkg::DayW-1:0]      req_first_end_day,
   input  logic [dpo_pkg::MonW-1:0]      req_first_end_month,
   input  logic [dpo_pkg::YearW-1:0]     req_first_end_year,
   input  logic [dpo_pkg::DayW-1:0]      req_second_start_day,
   input  logic [dpo_pkg::MonW-1:0]      req_second_start_month,
   input  logic [dpo_pkg::YearW-1:0]     req_second_start_year,
   input  logic [dpo_pkg::DayW-1:0]      req_second_end_day,
   input  logic [dpo_pkg::MonW-1:0]      req_second_end_month,
   input  logic [dpo_pkg::YearW-1:0]     req_second_end_year,
   output logic                          rsp_valid,
   output logic [dpo_pkg::CountW-1:0]    rsp_overlap_days,
   output logic                          rsp_date_invalid
);
   import dpo_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_CMP  = 4'b0100,
      ST_CNT  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [1:0]         idx_ff, idx_in;
   logic               bad_ff, bad_in;

   logic [DayW-1:0]    day_ff [4];
   logic [MonW-1:0]    mon_ff [4];
   logic [YearW-1:0]   year_ff [4];
   logic [NumW-1:0]    num_ff [4];
   logic [NumW-1:0]    lo_ff, hi_ff;
   logic               ord_ff;

   logic               valid_ff, valid_in;
   logic [CountW-1:0]  cnt_ff, cnt_in;
   logic               inv_ff;

   logic               accept;
   dpo_ctl_type        ctl;
   dpo_res_type        res;
   logic [NumW:0]      diff;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   assign ctl.en = (state_ff == ST_CONV);
   assign ctl.op = op_ff;

   dpo_date_unit u_date (
      .clock (clock),
      .ctl   (ctl),
      .day   (day_ff[idx_ff]),
      .month (mon_ff[idx_ff]),
      .year  (year_ff[idx_ff]),
      .res   (res)
   );

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      idx_in   = idx_ff;
      bad_in   = bad_ff;
      valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CONV;
               op_in    = OP_YDIV;
               idx_in   = 2'd0;
               bad_in   = 1'b0;
            end
         end
         ST_CONV: begin
            case (op_ff)
               OP_YDIV:  op_in = OP_YREM;
               OP_YREM:  op_in = OP_YYDIV;
               OP_YYDIV: op_in = OP_YYMUL;
               OP_YYMUL: op_in = OP_SUM;
               default: begin
                  op_in  = OP_YDIV;
                  bad_in = bad_ff || !res.ok;
                  idx_in = idx_ff + 2'd1;
                  if (idx_ff == 2'd3) begin
                     state_in = ST_CMP;
                  end
               end
            endcase
         end
         ST_CMP: begin
            state_in = ST_CNT;
         end
         ST_CNT: begin
            state_in = ST_IDLE;
            valid_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_YDIV;
         idx_ff   <= 2'd0;
         bad_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         idx_ff   <= idx_in;
         bad_ff   <= bad_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         day_ff[0]  <= req_first_start_day;
         mon_ff[0]  <= req_first_start_month;
         year_ff[0] <= req_first_start_year;
         day_ff[1]  <= req_first_end_day;
         mon_ff[1]  <= req_first_end_month;
         year_ff[1] <= req_first_end_year;
         day_ff[2]  <= req_second_start_day;
         mon_ff[2]  <= req_second_start_month;
         year_ff[2] <= req_second_start_year;
         day_ff[3]  <= req_second_end_day;
         mon_ff[3]  <= req_second_end_month;
         year_ff[3] <= req_second_end_year;
      end
      if ((state_ff == ST_CONV) && (op_ff == OP_SUM)) begin
         num_ff[idx_ff] <= res.num;
      end
   end

   // latest start and earliest end of the two periods, and whether each period is in order
   always_ff @(posedge clock) begin
      if (state_ff == ST_CMP) begin
         lo_ff  <= (num_ff[0] > num_ff[2]) ? num_ff[0] : num_ff[2];
         hi_ff  <= (num_ff[1] < num_ff[3]) ? num_ff[1] : num_ff[3];
         ord_ff <= (num_ff[0] <= num_ff[1]) && (num_ff[2] <= num_ff[3]);
      end
   end

   always_comb begin
      diff = {1'b0, hi_ff} - {1'b0, lo_ff} + (NumW+1)'(1);
      if (bad_ff || !ord_ff || (lo_ff > hi_ff)) begin
         cnt_in = '0;
      end else if (diff > (NumW+1)'(CountMax)) begin
         cnt_in = CountMax;
      end else begin
         cnt_in = diff[CountW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CNT) begin
         cnt_ff <= cnt_in;
         inv_ff <= bad_ff;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_overlap_days = cnt_ff;
   assign rsp_date_invalid = inv_ff;

endmodule

FILE: design/dpo_checker.sv
// port-level checker for the overlap block, bound to the top level
module dpo_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic [dpo_pkg::CountW-1:0]  rsp_overlap_days,
   input logic                        rsp_date_invalid
);
   import dpo_pkg::*;

   // an accepted item keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after item accepted");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // a result only appears once the work is done
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_date_invalid) |-> (rsp_overlap_days == '0))
      else $error("nonzero count with invalid date");

endmodule

bind date_period_overlap_days_top dpo_checker u_dpo_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_overlap_days (rsp_overlap_days),
   .rsp_date_invalid (rsp_date_invalid)
);
